FILE: src/mia_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and state encodings for the adjugate matrix inverter.
// No dependencies; every other file imports this package.
package mia_pkg;

  // Matrix geometry
  localparam int unsigned MAX_ORDER = 8;
  localparam int unsigned ORD_W     = 4;
  localparam int unsigned ROW_W     = $clog2(MAX_ORDER);
  localparam int unsigned IDX_W     = $clog2(MAX_ORDER * MAX_ORDER);
  localparam int unsigned MASK_W    = MAX_ORDER;
  localparam int unsigned ELEM_W    = 16;

  // Exact minor width: an 8x8 determinant of Q8.8 raw values stays below 2^134
  localparam int unsigned DW        = 136;
  localparam int unsigned HALF_W    = DW / 2;
  localparam int unsigned PROD_W    = HALF_W + 1 + ELEM_W;

  // Divider: numerator scaled by 2^24 and doubled for rounding, plus saturation headroom
  localparam int unsigned RES_W     = 32;
  localparam int unsigned FRAC_SH   = 25;
  localparam int unsigned SAT_SH    = RES_W + 1;
  localparam int unsigned XW        = DW + SAT_SH + 1;
  localparam int unsigned CNT_W     = $clog2(RES_W) + 1;

  // Queue between front and engine
  localparam int unsigned QDEPTH    = 2;
  localparam int unsigned QPTR_W    = $clog2(QDEPTH);
  localparam int unsigned QCNT_W    = $clog2(QDEPTH) + 1;

  localparam logic [ORD_W-1:0] ORDER_RST = 4'd4;

  // One loaded element, tagged by the front
  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } qitem_t;

  // One division request from the engine to the divider
  typedef struct packed {
    logic [DW-1:0] minor;
    logic          flip;
    logic          singular;
    logic          last;
  } job_t;

  typedef enum logic [3:0] {
    E_LOAD,
    E_ISSUE,
    E_MLO,
    E_MHI,
    E_ADDH,
    E_WRITE,
    E_PEND,
    E_SING,
    E_OREAD,
    E_OSEND
  } eng_state_e;

  typedef enum logic [2:0] {
    D_IDLE,
    D_PREP,
    D_INIT,
    D_STEP,
    D_FIN
  } div_state_e;

endpackage

FILE: src/mia_front.sv
`timescale 1ns / 1ps
// Input front: order register, load counter, tagging of the final element of a matrix.
// Depends on mia_pkg.
module mia_front
  import mia_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ORD_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  input  logic [ELEM_W-1:0] element_i,
  output logic              in_stall_o,
  input  logic              q_full_i,
  output logic              q_push_o,
  output qitem_t            q_item_o,
  output logic [ORD_W-1:0]  order_n_o
);

  logic [ORD_W-1:0]   order_q;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic [ORD_W-1:0]   n;
  logic [2*ORD_W-1:0] total;
  logic               accept;
  logic               is_last;

  // effective order, clamped to 1..MAX_ORDER
  always_comb begin
    if (order_q == '0) begin
      n = ORD_W'(1);
    end else if (order_q > ORD_W'(MAX_ORDER)) begin
      n = ORD_W'(MAX_ORDER);
    end else begin
      n = order_q;
    end
  end

  assign total   = {{ORD_W{1'b0}}, n} * {{ORD_W{1'b0}}, n};
  assign is_last = ({{(2*ORD_W-IDX_W){1'b0}}, cnt_q} == total - 1'b1);
  assign accept  = in_valid_i && !q_full_i;

  // load position; an order write drops any partial load
  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      cnt_d = '0;
    end else if (accept) begin
      cnt_d = is_last ? '0 : cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      order_q <= ORDER_RST;
      cnt_q   <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (cfg_we_i) begin
        order_q <= cfg_data_i;
      end
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = accept;
  assign q_item_o   = '{elem: element_i, idx: cnt_q, last: is_last};
  assign order_n_o  = n;

endmodule

FILE: src/mia_fifo.sv
`timescale 1ns / 1ps
// Two-entry request queue between the front and the compute engine.
// Depends on mia_pkg.
module mia_fifo
  import mia_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  qitem_t item_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output qitem_t item_o
);

  qitem_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wp_q, rp_q;
  logic [QCNT_W-1:0]   cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wp_q <= wp_q + 1'b1;
      end
      if (pop_i) begin
        rp_q <= rp_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rp_q];

endmodule

FILE: src/mia_engine.sv
`timescale 1ns / 1ps
// Compute engine: matrix store, column-subset minor tables, determinant and minor store,
// then streams minors to the divider in output order. Depends on mia_pkg.
module mia_engine
  import mia_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [ORD_W-1:0] n_i,
  input  logic             q_valid_i,
  input  qitem_t           q_item_i,
  output logic             q_pop_o,
  output logic             job_valid_o,
  output job_t             job_o,
  input  logic             job_ready_i,
  output logic [DW-1:0]    det_o
);

  eng_state_e state_q, state_d;

  logic [ROW_W-1:0]  pass_q, pass_d;
  logic [ROW_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  oi_q, oi_d;
  logic [ROW_W-1:0]  oj_q, oj_d;
  logic [MASK_W-1:0] mask_q, mask_d;
  logic              par_q, par_d;
  logic signed [DW-1:0]     acc_q, acc_d;
  logic signed [DW-1:0]     det_q, det_d;
  logic signed [PROD_W-1:0] prod_q, prod_d;

  // storage
  logic [ELEM_W-1:0] mat_mem_q [MAX_ORDER*MAX_ORDER];
  logic [DW-1:0]     dp_mem_q  [2**MASK_W];
  logic [DW-1:0]     cof_mem_q [MAX_ORDER*MAX_ORDER];
  logic [ELEM_W-1:0] mat_rd_q;
  logic [DW-1:0]     dp_rd_q;
  logic [DW-1:0]     cof_rd_q;

  logic              mat_we, rd_en, dp_we, cof_we, cof_re;
  logic [IDX_W-1:0]  mat_ra;
  logic [MASK_W-1:0] dp_ra;

  // derived geometry
  logic [ORD_W-1:0]  nm1_w;
  logic [ROW_W-1:0]  nm1;
  logic [MASK_W:0]   one_sh, full_ext;
  logic [MASK_W-1:0] full, limit;
  logic [ORD_W-1:0]  pc;
  logic [ORD_W-1:0]  ri_w;
  logic [ROW_W-1:0]  row;
  logic [ROW_W-1:0]  miss;
  logic [2*ORD_W-1:0] addr_w;
  logic signed [DW-1:0] lo_ext, hi_ext;
  logic              out_last;

  assign nm1_w    = n_i - 1'b1;
  assign nm1      = nm1_w[ROW_W-1:0];
  assign one_sh   = (MASK_W+1)'(1) << n_i;
  assign full_ext = one_sh - 1'b1;
  assign full     = full_ext[MASK_W-1:0];
  assign limit    = (pass_q == '0) ? full : full - 1'b1;

  // subset size and the column missing from an (n-1)-subset
  always_comb begin
    pc   = '0;
    miss = '0;
    for (int b = 0; b < MASK_W; b++) begin
      pc = pc + ORD_W'(mask_q[b]);
    end
    for (int b = MASK_W - 1; b >= 0; b--) begin
      if (!mask_q[b] && (ORD_W'(b) < n_i)) begin
        miss = ROW_W'(b);
      end
    end
  end

  // row used at this subset size; pass q skips row q, full subset uses row 0
  always_comb begin
    ri_w = n_i - pc - 1'b1;
    if (pc == n_i) begin
      row = '0;
    end else if (ri_w[ROW_W-1:0] < pass_q) begin
      row = ri_w[ROW_W-1:0];
    end else begin
      row = ri_w[ROW_W-1:0] + 1'b1;
    end
  end

  assign addr_w = {{(2*ORD_W-ROW_W){1'b0}}, row} * {{ORD_W{1'b0}}, n_i}
                  + {{(2*ORD_W-ROW_W){1'b0}}, col_q};
  assign mat_ra = addr_w[IDX_W-1:0];
  assign dp_ra  = mask_q ^ (MASK_W'(1) << col_q);

  assign lo_ext = DW'(prod_q);
  assign hi_ext = {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};

  // memories
  always_ff @(posedge clk_i) begin
    if (mat_we) begin
      mat_mem_q[q_item_i.idx] <= q_item_i.elem;
    end
    if (rd_en) begin
      mat_rd_q <= mat_mem_q[mat_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_we) begin
      dp_mem_q[mask_q] <= acc_q;
    end
    if (rd_en) begin
      dp_rd_q <= dp_mem_q[dp_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cof_we) begin
      cof_mem_q[{pass_q, miss}] <= acc_q;
    end
    if (cof_re) begin
      cof_rd_q <= cof_mem_q[{oj_q, oi_q}];
    end
  end

  assign out_last = (oi_q == nm1) && (oj_q == nm1);

  always_comb begin
    job_o.minor    = cof_rd_q;
    job_o.flip     = oi_q[0] ^ oj_q[0];
    job_o.singular = (state_q == E_SING);
    job_o.last     = (state_q == E_SING) || out_last;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    col_d       = col_q;
    oi_d        = oi_q;
    oj_d        = oj_q;
    mask_d      = mask_q;
    par_d       = par_q;
    acc_d       = acc_q;
    det_d       = det_q;
    prod_d      = prod_q;
    q_pop_o     = 1'b0;
    mat_we      = 1'b0;
    rd_en       = 1'b0;
    dp_we       = 1'b0;
    cof_we      = 1'b0;
    cof_re      = 1'b0;
    job_valid_o = 1'b0;
    case (state_q)
      E_LOAD: begin
        q_pop_o = q_valid_i;
        mat_we  = q_valid_i;
        if (q_valid_i && q_item_i.last) begin
          pass_d  = '0;
          mask_d  = '0;
          col_d   = '0;
          par_d   = 1'b0;
          acc_d   = DW'(1);
          state_d = E_ISSUE;
        end
      end
      E_ISSUE: begin
        if (mask_q[col_q]) begin
          rd_en   = 1'b1;
          state_d = E_MLO;
        end else if (col_q == nm1) begin
          state_d = E_WRITE;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
      E_MLO: begin
        prod_d  = $signed({1'b0, dp_rd_q[HALF_W-1:0]}) * $signed(mat_rd_q);
        state_d = E_MHI;
      end
      E_MHI: begin
        acc_d   = par_q ? acc_q - lo_ext : acc_q + lo_ext;
        prod_d  = $signed(dp_rd_q[DW-1:HALF_W]) * $signed(mat_rd_q);
        state_d = E_ADDH;
      end
      E_ADDH: begin
        acc_d = par_q ? acc_q - hi_ext : acc_q + hi_ext;
        par_d = ~par_q;
        if (col_q == nm1) begin
          state_d = E_WRITE;
        end else begin
          col_d   = col_q + 1'b1;
          state_d = E_ISSUE;
        end
      end
      E_WRITE: begin
        dp_we = 1'b1;
        if (pc == nm1_w) begin
          cof_we = 1'b1;
        end
        if (mask_q == full) begin
          det_d = acc_q;
        end
        if (mask_q == limit) begin
          state_d = E_PEND;
        end else begin
          mask_d  = mask_q + 1'b1;
          col_d   = '0;
          par_d   = 1'b0;
          acc_d   = '0;
          state_d = E_ISSUE;
        end
      end
      E_PEND: begin
        if ((pass_q == '0) && (det_q == '0)) begin
          state_d = E_SING;
        end else if (pass_q == nm1) begin
          oi_d    = '0;
          oj_d    = '0;
          state_d = E_OREAD;
        end else begin
          pass_d  = pass_q + 1'b1;
          mask_d  = '0;
          col_d   = '0;
          par_d   = 1'b0;
          acc_d   = DW'(1);
          state_d = E_ISSUE;
        end
      end
      E_SING: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          state_d = E_LOAD;
        end
      end
      E_OREAD: begin
        cof_re  = 1'b1;
        state_d = E_OSEND;
      end
      E_OSEND: begin
        job_valid_o = 1'b1;
        if (job_ready_i) begin
          if (out_last) begin
            state_d = E_LOAD;
          end else begin
            if (oj_q == nm1) begin
              oj_d = '0;
              oi_d = oi_q + 1'b1;
            end else begin
              oj_d = oj_q + 1'b1;
            end
            state_d = E_OREAD;
          end
        end
      end
      default: begin
        state_d = E_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_LOAD;
      pass_q  <= '0;
      col_q   <= '0;
      oi_q    <= '0;
      oj_q    <= '0;
      mask_q  <= '0;
      par_q   <= 1'b0;
      det_q   <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      col_q   <= col_d;
      oi_q    <= oi_d;
      oj_q    <= oj_d;
      mask_q  <= mask_d;
      par_q   <= par_d;
      det_q   <= det_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    prod_q <= prod_d;
  end

  assign det_o = det_q;

endmodule

FILE: src/mia_div.sv
`timescale 1ns / 1ps
// Rounding divider: minor * 2^24 / det, ties away from zero, saturated to Q16.16,
// one quotient bit per cycle, with the output register. Depends on mia_pkg.
module mia_div
  import mia_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             job_ready_o,
  input  logic [DW-1:0]    det_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [RES_W-1:0] inverse_element_o,
  output logic             singular_o,
  output logic             last_o
);

  localparam logic [RES_W-1:0] POS_MAX = {1'b0, {(RES_W-1){1'b1}}};
  localparam logic [RES_W-1:0] NEG_MAX = {1'b1, {(RES_W-1){1'b0}}};

  div_state_e state_q, state_d;

  logic [DW-1:0]    minor_q, minor_d;
  logic             flip_q, flip_d;
  logic             sing_q, sing_d;
  logic             last_q, last_d;
  logic [DW-1:0]    an_q, an_d;
  logic [DW-1:0]    ad_q, ad_d;
  logic             neg_q, neg_d;
  logic             sat_q, sat_d;
  logic [XW-1:0]    rem_q, rem_d;
  logic [XW-1:0]    dsh_q, dsh_d;
  logic [RES_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             ovalid_q, ovalid_d;
  logic [RES_W-1:0] res_q, res_d;
  logic             osing_q, osing_d;
  logic             olast_q, olast_d;

  logic             hit;
  logic             load;
  logic [RES_W-1:0] result;

  assign hit = (rem_q >= dsh_q);

  // sign handling and saturation of the finished quotient; a singular job gives zero
  always_comb begin
    if (sing_q) begin
      result = '0;
    end else if (sat_q) begin
      result = neg_q ? NEG_MAX : POS_MAX;
    end else if (!neg_q) begin
      result = (quo_q > POS_MAX) ? POS_MAX : quo_q;
    end else begin
      result = (quo_q > NEG_MAX) ? NEG_MAX : (~quo_q + 1'b1);
    end
  end

  always_comb begin
    state_d     = state_q;
    minor_d     = minor_q;
    flip_d      = flip_q;
    sing_d      = sing_q;
    last_d      = last_q;
    an_d        = an_q;
    ad_d        = ad_q;
    neg_d       = neg_q;
    sat_d       = sat_q;
    rem_d       = rem_q;
    dsh_d       = dsh_q;
    quo_d       = quo_q;
    cnt_d       = cnt_q;
    job_ready_o = 1'b0;
    load        = 1'b0;
    case (state_q)
      D_IDLE: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          minor_d = job_i.minor;
          flip_d  = job_i.flip;
          sing_d  = job_i.singular;
          last_d  = job_i.last;
          sat_d   = 1'b0;
          quo_d   = '0;
          state_d = job_i.singular ? D_FIN : D_PREP;
        end
      end
      D_PREP: begin
        an_d    = minor_q[DW-1] ? (~minor_q + 1'b1) : minor_q;
        ad_d    = det_i[DW-1] ? (~det_i + 1'b1) : det_i;
        neg_d   = minor_q[DW-1] ^ det_i[DW-1] ^ flip_q;
        state_d = D_INIT;
      end
      D_INIT: begin
        // doubled scaled numerator plus divisor gives round to nearest
        rem_d   = (XW'(an_q) << FRAC_SH) + XW'(ad_q);
        dsh_d   = XW'(ad_q) << SAT_SH;
        cnt_d   = CNT_W'(RES_W);
        state_d = D_STEP;
      end
      D_STEP: begin
        if (cnt_q == CNT_W'(RES_W)) begin
          // top step only detects a quotient that overflows 32 bits
          if (hit) begin
            sat_d   = 1'b1;
            state_d = D_FIN;
          end else begin
            dsh_d = dsh_q >> 1;
            cnt_d = cnt_q - 1'b1;
          end
        end else begin
          if (hit) begin
            rem_d = rem_q - dsh_q;
          end
          quo_d = {quo_q[RES_W-2:0], hit};
          dsh_d = dsh_q >> 1;
          if (cnt_q == '0) begin
            state_d = D_FIN;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      D_FIN: begin
        if (!ovalid_q || !out_stall_i) begin
          load    = 1'b1;
          state_d = D_IDLE;
        end
      end
      default: begin
        state_d = D_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    ovalid_d = ovalid_q;
    res_d    = res_q;
    osing_d  = osing_q;
    olast_d  = olast_q;
    if (load) begin
      ovalid_d = 1'b1;
      res_d    = result;
      osing_d  = sing_q;
      olast_d  = last_q;
    end else if (ovalid_q && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= D_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    minor_q <= minor_d;
    flip_q  <= flip_d;
    sing_q  <= sing_d;
    last_q  <= last_d;
    an_q    <= an_d;
    ad_q    <= ad_d;
    neg_q   <= neg_d;
    sat_q   <= sat_d;
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    cnt_q   <= cnt_d;
    res_q   <= res_d;
    osing_q <= osing_d;
    olast_q <= olast_d;
  end

  assign out_valid_o       = ovalid_q;
  assign inverse_element_o = res_q;
  assign singular_o        = osing_q;
  assign last_o            = olast_q;

endmodule

FILE: src/matrix_inverse_adjugate_top.sv
`timescale 1ns / 1ps
// Matrix inverse by adjugate and determinant: top level.
// Instantiates mia_front, mia_fifo, mia_engine and mia_div; depends on mia_pkg.
//
// Usage: write the order (1..8, reset 4; 0 acts as 1, above 8 as 8) through cfg_we_i /
// cfg_data_i while the block is idle; a write also drops any partly loaded matrix.
// Elements arrive on in_valid_i / element_i (signed Q8.8, row-major) and are taken
// when in_stall_o is low. After the n*n-th element the block works out the exact
// determinant and all minors, then returns n*n inverse elements in row-major order
// (signed Q16.16, rounded, saturated) on out_valid_o, last_o set on the final one.
// A zero determinant gives a single result with singular_o and last_o set.
// Timing: elements load at one per cycle into a two-entry queue while it is not full.
// The minor engine makes up to n passes over the column subsets, the full subset
// only in the first; a zero determinant ends it after the first pass. Each term
// takes two 68x16 products, one for each half of the stored minor, in turn.
// Each result then goes through the bit-serial divider.
// The next matrix may be loaded while results are still going out, up to the queue.
// Reset clears control state and sets the order to 4; stores need no clearing.
// A stalled receiver holds the result in the output register and backs up the
// divider and engine; the input side stalls once the queue is full.
module matrix_inverse_adjugate_top
  import mia_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ORD_W-1:0]  cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [ELEM_W-1:0] element_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [RES_W-1:0]  inverse_element_o,
  output logic              singular_o,
  output logic              last_o
);

  logic             q_push, q_full, q_valid, q_pop;
  qitem_t           q_in, q_out;
  logic [ORD_W-1:0] order_n;
  logic             job_valid, job_ready;
  job_t             job;
  logic [DW-1:0]    det;

  mia_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .element_i  (element_i),
    .in_stall_o (in_stall_o),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (q_in),
    .order_n_o  (order_n)
  );

  mia_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_out)
  );

  mia_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (order_n),
    .q_valid_i   (q_valid),
    .q_item_i    (q_out),
    .q_pop_o     (q_pop),
    .job_valid_o (job_valid),
    .job_o       (job),
    .job_ready_i (job_ready),
    .det_o       (det)
  );

  mia_div u_div (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (job_valid),
    .job_i             (job),
    .job_ready_o       (job_ready),
    .det_i             (det),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .inverse_element_o (inverse_element_o),
    .singular_o        (singular_o),
    .last_o            (last_o)
  );

  // a singular result is always the only and last one, with a zero value
  a_sing_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> last_o && (inverse_element_o == '0))
    else $error("singular result without last or with nonzero value");

  // the divider is busy for the cycle after it takes a request
  a_div_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid && job_ready |=> !job_ready)
    else $error("divider took back-to-back requests");

  // the engine only pops a queue that holds an element
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

endmodule
